### rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shorthand for clocked assertions on clk with reset rst_n held off.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error(msg);

`endif

### rtl/core/bufr_pkg.sv
// ============================================================================
// bufr_pkg
// Shared types and constants of the byte-unstuffing frame receiver.
// ============================================================================
`default_nettype none

package bufr_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 7;
    localparam int EVENT_W = 2;

    // Default frame buffer depth
    localparam int BUFR_DEPTH_DEF = 80;

    // Framing bytes
    localparam logic [BYTE_W-1:0] DELIM     = 8'h12;
    localparam logic [BYTE_W-1:0] ESC       = 8'hDB;
    localparam logic [BYTE_W-1:0] ESC_DELIM = 8'hDE;
    localparam logic [BYTE_W-1:0] ESC_ESC   = 8'hDD;

    // Frame length minus size byte
    localparam logic [BYTE_W:0] SIZE_OVERHEAD = 9'd5;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MAX = 1'b1;
    localparam logic [BYTE_W-1:0] SIZE_MIN_RST = 8'd16;
    localparam logic [BYTE_W-1:0] SIZE_MAX_RST = 8'd34;

    // Input beat function codes
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_STORED  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CLOSED  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DROPPED = 2'd2;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [FILL_W-1:0]  write_index;
        logic [BYTE_W-1:0]  write_data;
        logic [FILL_W-1:0]  frame_length;
        logic               length_ok;
    } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/bufr_decoder.sv
// ============================================================================
// bufr_decoder
// Framing state machine: delimiter hunt, size check, unstuffing, close/hold.
// ============================================================================
`default_nettype none

module bufr_decoder
    import bufr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFR_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire in_beat_t          beat,
    input  wire logic [BYTE_W-1:0] size_min,
    input  wire logic [BYTE_W-1:0] size_max,
    output logic                   res_valid,
    output out_beat_t              res
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_SIZE,
        PH_FRAME,
        PH_HELD
    } phase_t;

    localparam logic [FILL_W-1:0] DEPTH = FILL_W'(BUFFER_DEPTH);
    localparam logic [FILL_W-1:0] ONE   = FILL_W'(1);

    phase_t             phase_reg, phase_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic [BYTE_W-1:0]  size_reg, size_next;

    logic              esc_pair;
    logic [FILL_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic [FILL_W-1:0] len;

    // Decode one beat against the current state
    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        prev_next  = prev_reg;
        size_next  = size_reg;
        res_valid  = 1'b0;
        res        = '0;
        esc_pair   = (prev_reg == ESC) && ((beat.data_byte == ESC_DELIM) ||
                                           (beat.data_byte == ESC_ESC));
        idx        = fill_reg;
        val        = beat.data_byte;
        len        = fill_reg + ONE;

        if (beat.func == FUNC_BYTE)
        begin
            prev_next = beat.data_byte;
            case (phase_reg)
                PH_WAIT:
                begin
                    // hunt for the opening delimiter, store it at slot 0
                    if (beat.data_byte == DELIM)
                    begin
                        fill_next        = ONE;
                        phase_next       = PH_SIZE;
                        res_valid        = 1'b1;
                        res.event_res    = EV_STORED;
                        res.write_data   = beat.data_byte;
                        res.frame_length = ONE;
                    end
                end
                PH_SIZE:
                begin
                    res_valid = 1'b1;
                    if ((beat.data_byte >= size_min) && (beat.data_byte <= size_max))
                    begin
                        size_next        = beat.data_byte;
                        fill_next        = len;
                        phase_next       = PH_FRAME;
                        res.event_res    = EV_STORED;
                        res.write_index  = fill_reg;
                        res.write_data   = beat.data_byte;
                        res.frame_length = len;
                    end
                    else
                    begin
                        // drop on a size byte out of range
                        fill_next     = '0;
                        phase_next    = PH_WAIT;
                        res.event_res = EV_DROPPED;
                    end
                end
                PH_FRAME:
                begin
                    res_valid = 1'b1;
                    if (fill_reg < DEPTH)
                    begin
                        if (esc_pair)
                        begin
                            // rewrite the escape byte in place
                            idx = fill_reg - ONE;
                            val = (beat.data_byte == ESC_DELIM) ? DELIM : ESC;
                            len = fill_reg;
                            if (idx == ONE)
                            begin
                                size_next = val;
                            end
                        end
                        fill_next        = len;
                        res.event_res    = EV_STORED;
                        res.write_index  = idx;
                        res.write_data   = val;
                        res.frame_length = len;
                        // close on a delimiter and check the length
                        if (beat.data_byte == DELIM)
                        begin
                            phase_next    = PH_HELD;
                            res.event_res = EV_CLOSED;
                            res.length_ok = ({2'b00, len} ==
                                             ({1'b0, size_reg} + SIZE_OVERHEAD));
                        end
                    end
                    else
                    begin
                        // drop when the buffer is full
                        fill_next     = '0;
                        phase_next    = PH_WAIT;
                        res.event_res = EV_DROPPED;
                    end
                end
                PH_HELD:
                begin
                    // hold the closed frame, ignore bytes
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
        else if (phase_reg == PH_HELD)
        begin
            // release the held frame
            phase_next = PH_WAIT;
            fill_next  = '0;
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            fill_reg  <= '0;
            prev_reg  <= '0;
            size_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            prev_reg  <= prev_next;
            size_reg  <= size_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/byte_unstuffing_frame_receiver_unit.sv
// ============================================================================
// byte_unstuffing_frame_receiver_unit
// Receives serial bytes, finds delimited frames, removes byte stuffing and
// reports each stored byte, frame close with length check, or frame drop.
// ============================================================================
//
//   channel   | signals                          | payload
//   ----------+----------------------------------+----------------------------
//   input     | in_valid / in_ready / in_data    | func, data_byte
//   output    | out_valid / out_ready / out_data | event, index, data, length
//   config    | cfg_we / cfg_idx / cfg_wdata     | size_min, size_max
//
// One beat is accepted per cycle; any result appears in the output register
// on the next cycle. in_ready is high whenever the output register is empty
// or being drained, so throughput is one beat per cycle while out_ready holds.
// A stalled output blocks input only while a result is waiting.
// Reset clears the framing state and loads the default size limits.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module byte_unstuffing_frame_receiver_unit
    import bufr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFR_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_beat_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_beat_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [BYTE_W-1:0]    cfg_wdata
);

    logic [BYTE_W-1:0] size_min_reg;
    logic [BYTE_W-1:0] size_max_reg;
    logic              step_en;
    logic              res_valid;
    out_beat_t         res;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg;

    // Accept a beat when the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign step_en  = in_valid && in_ready;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_min_reg <= SIZE_MIN_RST;
            size_max_reg <= SIZE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SIZE_MIN: size_min_reg <= cfg_wdata;
                REG_SIZE_MAX: size_max_reg <= cfg_wdata;
                default:      size_min_reg <= size_min_reg;
            endcase
        end
    end

    bufr_decoder #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .beat      (in_data),
        .size_min  (size_min_reg),
        .size_max  (size_max_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load the output register with a new result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (step_en && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `ASSERT_SAME(a_drop_zero, out_valid && (out_data.event_res == EV_DROPPED), (out_data.frame_length == '0) && !out_data.length_ok, "dropped frame carries nonzero fields")
    `ASSERT_SAME(a_ok_on_close, out_valid && out_data.length_ok, out_data.event_res == EV_CLOSED, "length_ok outside a frame close")
    `ASSERT_SAME(a_len_bound, out_valid, out_data.frame_length <= FILL_W'(BUFFER_DEPTH), "frame length beyond buffer depth")
    `ASSERT_NEXT(a_release_silent, step_en && (in_data.func == FUNC_RELEASE), out_valid == ($past(out_valid) && !$past(out_ready)), "release beat produced a result")
    `ASSERT_NEXT(a_cfg_min, cfg_we && (cfg_idx == REG_SIZE_MIN), size_min_reg == $past(cfg_wdata), "lower size limit not written")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Byte-unstuffing frame receiver testbench
// Streams delimited, byte-stuffed frames plus noise into the receiver under
// bursty input and a stalling output, predicts every stored byte, frame close
// and frame drop, and checks each result beat field by field. Size limits are
// reprogrammed between phases, inverted and extreme settings among them.
// ============================================================================
module testbench;
    import bufr_pkg::*;

    localparam int DEPTH       = BUFR_DEPTH_DEF;
    localparam int PHASE_BEATS = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 5;

    typedef enum logic [1:0] {RX_HUNT, RX_SIZE, RX_BODY, RX_HELD} rx_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_SIZE_MIN;
    logic [BYTE_W-1:0] cfg_wdata = '0;

    // Stimulus waiting to be sent and results waiting to be seen
    in_beat_t  pending_bytes[$];
    out_beat_t expected_writes[$];
    int fail_count = 0;

    // Receiver state as the testbench sees it
    rx_phase_t   rx_phase;
    logic [6:0]  fill_lvl;
    logic [7:0]  last_byte;
    logic [7:0]  frame_size;
    logic [7:0]  lim_min;
    logic [7:0]  lim_max;

    byte_unstuffing_frame_receiver_unit #(.BUFFER_DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the receiver state by one accepted beat, queue its result
    task automatic decode_rx_byte(input in_beat_t b);
        out_beat_t  r;
        logic       emit;
        logic [7:0] ch;
        logic [7:0] prev;
        r    = '0;
        emit = 1'b0;
        ch   = b.data_byte;
        prev = last_byte;
        if (b.func == FUNC_RELEASE)
        begin
            if (rx_phase == RX_HELD)
            begin
                rx_phase = RX_HUNT;
                fill_lvl = '0;
            end
        end
        else
        begin
            case (rx_phase)
                RX_HUNT:
                begin
                    if (ch == DELIM)
                    begin
                        fill_lvl       = 7'd1;
                        rx_phase       = RX_SIZE;
                        r.event_res    = EV_STORED;
                        r.write_data   = ch;
                        r.frame_length = fill_lvl;
                        emit           = 1'b1;
                    end
                end
                RX_SIZE:
                begin
                    if (ch >= lim_min && ch <= lim_max)
                    begin
                        frame_size     = ch;
                        r.event_res    = EV_STORED;
                        r.write_index  = fill_lvl;
                        r.write_data   = ch;
                        fill_lvl       = fill_lvl + 7'd1;
                        r.frame_length = fill_lvl;
                        rx_phase       = RX_BODY;
                    end
                    else
                    begin
                        fill_lvl    = '0;
                        rx_phase    = RX_HUNT;
                        r.event_res = EV_DROPPED;
                    end
                    emit = 1'b1;
                end
                RX_BODY:
                begin
                    if (int'(fill_lvl) < DEPTH)
                    begin
                        r.event_res = EV_STORED;
                        // an escape pair rewrites the byte before it
                        if (prev == ESC && (ch == ESC_DELIM || ch == ESC_ESC))
                        begin
                            r.write_index = fill_lvl - 7'd1;
                            r.write_data  = (ch == ESC_DELIM) ? DELIM : ESC;
                            if (r.write_index == 7'd1)
                                frame_size = r.write_data;
                        end
                        else
                        begin
                            r.write_index = fill_lvl;
                            r.write_data  = ch;
                            fill_lvl      = fill_lvl + 7'd1;
                        end
                        if (ch == DELIM)
                        begin
                            rx_phase    = RX_HELD;
                            r.event_res = EV_CLOSED;
                            r.length_ok = (int'(fill_lvl) ==
                                           int'(frame_size) + int'(SIZE_OVERHEAD));
                        end
                        r.frame_length = fill_lvl;
                    end
                    else
                    begin
                        fill_lvl    = '0;
                        rx_phase    = RX_HUNT;
                        r.event_res = EV_DROPPED;
                    end
                    emit = 1'b1;
                end
                default: ;
            endcase
            last_byte = ch;
        end
        if (emit)
            expected_writes.push_back(r);
    endtask

    task automatic push_beat(input logic f, input logic [7:0] d);
        in_beat_t b;
        b.func      = f;
        b.data_byte = d;
        pending_bytes.push_back(b);
    endtask

    // One frame with random content: mostly well formed, sometimes broken
    task automatic build_frame();
        int sz;
        int target;
        int n;
        int r;
        logic [7:0] b;
        // noise ahead of the frame
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) push_beat(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            push_beat(FUNC_RELEASE, 8'($urandom_range(0, 255)));
        push_beat(FUNC_BYTE, DELIM);
        if (lim_min <= lim_max && $urandom_range(0, 9) != 0)
            sz = int'(lim_min) + $urandom_range(0, (lim_max - lim_min > 24) ? 24
                                                  : int'(lim_max - lim_min));
        else
            sz = $urandom_range(0, 255);
        push_beat(FUNC_BYTE, 8'(sz));
        // decoded body length that makes the length check pass, or near it
        target = sz + 2;
        if ($urandom_range(0, 3) == 0)
            target = target + int'($urandom_range(0, 4)) - 2;
        if (target > DEPTH + 4)
            target = DEPTH + 4;
        if (target < 0)
            target = 0;
        for (int k = 0; k < target; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                push_beat(FUNC_BYTE, ESC);
                push_beat(FUNC_BYTE, ESC_DELIM);
            end
            else if (r == 1)
            begin
                push_beat(FUNC_BYTE, ESC);
                push_beat(FUNC_BYTE, ESC_ESC);
            end
            else if (r == 2 && $urandom_range(0, 7) == 0)
                push_beat(FUNC_BYTE, DELIM);
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == DELIM)
                    b = 8'h13;
                push_beat(FUNC_BYTE, b);
            end
        end
        push_beat(FUNC_BYTE, DELIM);
        // bytes that arrive while the frame is held
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n) push_beat(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 11) != 0)
            push_beat(FUNC_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    // Hold until every beat is sent and every result seen, then let it settle
    task automatic wait_idle();
        @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == REG_SIZE_MIN)
            lim_min = val;
        else
            lim_max = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_rx_byte(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_bytes.pop_front();
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern cycles through calm, light, long and heavy stretches
    int stall_left = 0;
    int rx_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            rx_tick    = 0;
        end
        else
        begin
            // check the beat handed over at this edge
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: ev=%0d idx=%0d data=%h len=%0d ok=%0d",
                                 out_data.event_res, out_data.write_index,
                                 out_data.write_data, out_data.frame_length,
                                 out_data.length_ok);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (out_data.event_res !== want.event_res ||
                        out_data.write_index !== want.write_index ||
                        out_data.write_data !== want.write_data ||
                        out_data.frame_length !== want.frame_length ||
                        out_data.length_ok !== want.length_ok)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected ev=%0d idx=%0d data=%h len=%0d ok=%0d,",
                                      " got ev=%0d idx=%0d data=%h len=%0d ok=%0d"},
                                     want.event_res, want.write_index, want.write_data,
                                     want.frame_length, want.length_ok,
                                     out_data.event_res, out_data.write_index,
                                     out_data.write_data, out_data.frame_length,
                                     out_data.length_ok);
                    end
                end
            end
            rx_tick++;
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                case ((rx_tick >> 7) & 3)
                    1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
                    2: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
                    3: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 4);
                    default: ;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] lo_set[6];
        logic [7:0] hi_set[6];
        rx_phase   = RX_HUNT;
        fill_lvl   = '0;
        last_byte  = '0;
        frame_size = '0;
        lim_min    = SIZE_MIN_RST;
        lim_max    = SIZE_MAX_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Default limits: release while hunting, noise, sizes just outside the range
        push_beat(FUNC_RELEASE, 8'h00);
        push_beat(FUNC_BYTE, 8'hFF);
        push_beat(FUNC_BYTE, 8'h00);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_BYTE, SIZE_MIN_RST - 8'd1);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_BYTE, SIZE_MAX_RST + 8'd1);
        wait_idle();

        // Full range: escape over the size byte, escaped escape, held bytes,
        // a frame whose length matches, and a release outside the held state
        write_cfg(REG_SIZE_MIN, 8'd0);
        write_cfg(REG_SIZE_MAX, 8'd255);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_BYTE, ESC);
        push_beat(FUNC_BYTE, ESC_DELIM);
        push_beat(FUNC_BYTE, ESC);
        push_beat(FUNC_BYTE, ESC_ESC);
        push_beat(FUNC_BYTE, 8'h55);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_BYTE, ESC);
        push_beat(FUNC_RELEASE, 8'hFF);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_BYTE, 8'h00);
        push_beat(FUNC_BYTE, 8'hAA);
        push_beat(FUNC_BYTE, 8'hBB);
        push_beat(FUNC_BYTE, DELIM);
        push_beat(FUNC_RELEASE, 8'h00);
        push_beat(FUNC_RELEASE, 8'h00);
        wait_idle();

        // Random frames under a series of limit settings
        lo_set = '{SIZE_MIN_RST, 8'd0, 8'd200, 8'd255, 8'd0, 8'($urandom_range(0, 40))};
        hi_set = '{SIZE_MAX_RST, 8'd255, 8'd10, 8'd255, 8'd0, 8'd0};
        hi_set[5] = lo_set[5] + 8'($urandom_range(0, 60));
        for (int p = 0; p < 6; p++)
        begin
            write_cfg(REG_SIZE_MIN, lo_set[p]);
            write_cfg(REG_SIZE_MAX, hi_set[p]);
            while (pending_bytes.size() < PHASE_BEATS)
                build_frame();
            wait_idle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bufr_pkg.sv
rtl/core/bufr_decoder.sv
rtl/core/byte_unstuffing_frame_receiver_unit.sv
tb/sv/testbench.sv
